@@ sv/ssiq_pkg.sv @@
// ----------------------------------------------------------------------------
// ssiq_pkg
// Shared types and codes for the sorted insertion queue: item structs,
// result status codes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package ssiq_pkg;

    // item kind codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_POPPED   = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // input item
    typedef struct packed {
        logic               kind;
        logic signed [31:0] item_value;
    } t_in_item;

    // result item
    typedef struct packed {
        t_status            status;
        logic signed [31:0] head_value;
        logic        [4:0]  stored_count;
    } t_out_item;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_WR
    } t_state;

    // datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_COMPARE,
        DP_INSERT,
        DP_POP,
        DP_REPORT
    } t_dp_op;

    // controller to datapath
    typedef struct packed {
        t_dp_op  op;
        t_status code;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic kind;
        logic dup;
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

@@ sv/sorted_set_insert_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_set_insert_queue_top
// Sorted set of signed 32-bit values with insert and pop-smallest items.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item and raise start; the item is taken at a clock edge where
//   start is high and busy is low. kind 0 inserts item_value in sorted
//   place (refused as duplicate or full), kind 1 pops the smallest value
//   (or reports empty).
//   Each item gives one result on o_result, shown for one cycle with o_done
//   high. The receiver has no way to stall; it must take it that cycle.
// Timing:
//   An item passes through load, compare in every cell at once, then the
//   commit that shifts the cell row. o_done rises in the cycle after the
//   commit; busy falls at the edge that raises o_done, so a new item can
//   be taken while the result is on the ports.
// Reset:
//   i_rst_n low (synchronous) empties the set and clears busy and o_done.
//   Cell contents are not cleared; only cells below the count are read.
// ----------------------------------------------------------------------------
module sorted_set_insert_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ssiq_pkg::t_in_item  i_item,
    output ssiq_pkg::t_out_item o_result,
    output logic                o_done
);
    import ssiq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    ssiq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // cell row and result register
    ssiq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule

@@ sv/ssiq_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssiq_ctrl
// Sequencer: takes an item, runs the compare pass over the cells, then
// picks the commit action and result status from the datapath flags.
// ----------------------------------------------------------------------------
module ssiq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ssiq_pkg::t_dp_stat i_stat,
    output ssiq_pkg::t_dp_cmd  o_cmd
);
    import ssiq_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = DP_NOP;
        o_cmd.code = ST_INSERTED;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.op = DP_COMPARE;
                n_state  = S_WR;
            end
            S_WR: begin
                n_state = S_IDLE;
                if (i_stat.kind == KIND_INSERT) begin
                    // duplicate wins over full
                    if (i_stat.dup) begin
                        o_cmd.op   = DP_REPORT;
                        o_cmd.code = ST_DUP;
                    end else if (i_stat.full) begin
                        o_cmd.op   = DP_REPORT;
                        o_cmd.code = ST_FULL;
                    end else begin
                        o_cmd.op   = DP_INSERT;
                        o_cmd.code = ST_INSERTED;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.op   = DP_REPORT;
                        o_cmd.code = ST_EMPTY;
                    end else begin
                        o_cmd.op   = DP_POP;
                        o_cmd.code = ST_POPPED;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ sv/ssiq_dp.sv @@
// ----------------------------------------------------------------------------
// ssiq_dp
// Row of value cells held in ascending order. Each cell compares its
// value with the item value; commit shifts the row up for an insert or
// down for a pop, and loads the result register.
// ----------------------------------------------------------------------------
module ssiq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssiq_pkg::t_in_item  i_item,
    input  ssiq_pkg::t_dp_cmd   i_cmd,
    output ssiq_pkg::t_dp_stat  o_stat,
    output ssiq_pkg::t_out_item o_result,
    output logic                o_done
);
    import ssiq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic signed [31:0] r_entry [CAPACITY];
    logic        [CW-1:0] r_count;
    logic                 r_kind;
    logic signed [31:0]   r_value;
    logic [CAPACITY-1:0]  r_lt;
    logic                 r_dup;

    logic [CAPACITY-1:0]  n_lt;
    logic                 n_dup;
    logic signed [31:0]   ins_prev [CAPACITY];
    logic signed [31:0]   ins_next [CAPACITY];
    logic signed [31:0]   pop_next [CAPACITY];

    // per-cell compare, valid cells only
    always_comb begin
        n_dup = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            n_lt[i] = (CW'(i) < r_count) && (r_entry[i] < r_value);
            if ((CW'(i) < r_count) && (r_entry[i] == r_value)) begin
                n_dup = 1'b1;
            end
        end
    end

    // insert: cells below the slot keep, the slot takes the value,
    // cells above take their lower neighbor
    always_comb begin
        ins_prev[0] = r_value;
        for (int i = 1; i < CAPACITY; i++) begin
            ins_prev[i] = r_lt[i-1] ? r_value : r_entry[i-1];
        end
        for (int i = 0; i < CAPACITY; i++) begin
            ins_next[i] = r_lt[i] ? r_entry[i] : ins_prev[i];
        end
    end

    // pop: every cell but the top one takes its upper neighbor; the top cell keeps its value
    always_comb begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
            pop_next[i] = r_entry[i+1];
        end
        pop_next[CAPACITY-1] = r_entry[CAPACITY-1];
    end

    // item capture and compare flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_LOAD) begin
            r_kind  <= i_item.kind;
            r_value <= i_item.item_value;
        end
        if (i_cmd.op == DP_COMPARE) begin
            r_lt  <= n_lt;
            r_dup <= n_dup;
        end
    end

    // cell row
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_cmd.op == DP_INSERT) begin
                r_entry[i] <= ins_next[i];
            end else if (i_cmd.op == DP_POP) begin
                r_entry[i] <= pop_next[i];
            end
        end
    end

    // count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= (i_cmd.op == DP_INSERT) || (i_cmd.op == DP_POP) ||
                      (i_cmd.op == DP_REPORT);
            if (i_cmd.op == DP_INSERT) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.op == DP_POP) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_INSERT: begin
                o_result.status       <= i_cmd.code;
                o_result.head_value   <= '0;
                o_result.stored_count <= 5'(r_count + 1'b1);
            end
            DP_POP: begin
                o_result.status       <= i_cmd.code;
                o_result.head_value   <= r_entry[0];
                o_result.stored_count <= 5'(r_count - 1'b1);
            end
            DP_REPORT: begin
                o_result.status       <= i_cmd.code;
                o_result.head_value   <= '0;
                o_result.stored_count <= 5'(r_count);
            end
            default: ;
        endcase
    end

    assign o_stat.kind  = r_kind;
    assign o_stat.dup   = r_dup;
    assign o_stat.full  = (r_count == CAP_CNT);
    assign o_stat.empty = (r_count == '0);

endmodule

@@ bench/tb_sorted_set_insert_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_set_insert_queue_top
// Self-checking bench for the sorted insertion queue. A behavioral copy of
// the sorted set predicts the result of every accepted item. A monitor
// compares each strobed result against the oldest prediction. Stimulus runs
// in this order: directed corner cases (empty pop, extremes, duplicates,
// fill to capacity, duplicate while full), then random insert-heavy and
// pop-heavy bursts with random idle gaps and drain pauses.
// ----------------------------------------------------------------------------
module tb_sorted_set_insert_queue_top;
    import ssiq_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int CLK_HALF   = 6;
    localparam int CYCLE_LIMIT = 200000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    t_out_item o_result;
    logic      o_done;

    // shadow copy of the sorted set
    logic signed [31:0] held_values [CAPACITY];
    int                 held_count = 0;

    t_out_item pending_results [$];
    int        fail_count  = 0;
    int        cycle_count = 0;

    sorted_set_insert_queue_top #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_result (o_result),
        .o_done   (o_done)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("FAIL sorted_set_insert_queue_top");
            $finish;
        end
    end

    // apply one item to the shadow set and return the result it yields
    function automatic t_out_item apply_set_op(t_in_item it);
        t_out_item          res;
        logic signed [31:0] v;
        int                 pos;
        int                 i;
        v              = it.item_value;
        res.status     = ST_INSERTED;
        res.head_value = '0;
        if (it.kind == KIND_INSERT) begin
            pos = 0;
            while (pos < held_count && held_values[pos] < v) pos++;
            if (pos < held_count && held_values[pos] == v) begin
                res.status = ST_DUP;
            end else if (held_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                for (i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
                held_values[pos] = v;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.head_value = held_values[0];
                for (i = 1; i < held_count; i++) held_values[i-1] = held_values[i];
                held_count--;
                res.status = ST_POPPED;
            end
        end
        res.stored_count = 5'(held_count);
        return res;
    endfunction

    // result monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d head %0d count %0d", $time,
                         o_result.status, o_result.head_value, o_result.stored_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_result.status);
                    fail_count++;
                end
                if (o_result.head_value !== want.head_value) begin
                    $display("%0t: head_value expected %0d actual %0d", $time,
                             want.head_value, o_result.head_value);
                    fail_count++;
                end
                if (o_result.stored_count !== want.stored_count) begin
                    $display("%0t: stored_count expected %0d actual %0d", $time,
                             want.stored_count, o_result.stored_count);
                    fail_count++;
                end
            end
        end
    end

    // drive one item and hold it until the block takes it; start stays high
    task automatic send_item(input logic kind, input logic signed [31:0] value);
        t_in_item it;
        it.kind       = kind;
        it.item_value = value;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_set_op(it));
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // values biased toward collisions and extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1: return $signed($urandom_range(0, 16)) - 8;
            2: begin
                if (held_count > 0) return held_values[$urandom_range(0, held_count - 1)];
                return $urandom;
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh8000_0001;
                    default: return 32'sh7FFF_FFFE;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // sender holds off until every outstanding result has come back
    task automatic wait_all_results();
        if (pending_results.size() != 0) start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_pop();
        send_item(KIND_POP, 32'sd0);
        send_item(KIND_POP, 32'sh7FFF_FFFF);
    endtask

    task automatic test_extremes_and_dup();
        send_item(KIND_INSERT, 32'sh7FFF_FFFF);
        send_item(KIND_INSERT, 32'sh8000_0000);
        send_item(KIND_INSERT, 32'sd0);
        send_item(KIND_INSERT, -32'sd1);
        send_item(KIND_INSERT, 32'sd0);            // duplicate refused
        send_item(KIND_INSERT, 32'sh8000_0000);    // duplicate at the head
        send_item(KIND_POP, 32'sd0);               // smallest comes out
    endtask

    task automatic test_fill_full();
        int k;
        // three held; add thirteen more to reach capacity
        for (k = 0; k < 13; k++) send_item(KIND_INSERT, (k - 6) * 32'sd1000 + 32'sd7);
        send_item(KIND_INSERT, 32'sd12345);        // full refused
        send_item(KIND_INSERT, 32'sh7FFF_FFFF);    // duplicate wins over full
        send_item(KIND_INSERT, -32'sd1);
        send_item(KIND_POP, 32'sd0);
    endtask

    task automatic test_random_bursts();
        int burst;
        int k;
        int insert_pct;
        bit no_idle;
        for (burst = 0; burst < 10; burst++) begin
            insert_pct = (burst % 2 == 0) ? 80 : 25;
            no_idle    = (burst % 3 == 1);
            for (k = 0; k < 40; k++) begin
                if ($urandom_range(0, 99) < insert_pct)
                    send_item(KIND_INSERT, pick_value());
                else
                    send_item(KIND_POP, $urandom);
                if (!no_idle) idle_gap(pick_gap());
            end
            if (burst == 3 || burst == 7) wait_all_results();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pop();
        test_extremes_and_dup();
        test_fill_full();
        test_random_bursts();

        // drain and let the pipeline settle
        wait_all_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS sorted_set_insert_queue_top");
        end else begin
            $display("FAIL sorted_set_insert_queue_top");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ssiq_pkg.sv
sv/ssiq_ctrl.sv
sv/ssiq_dp.sv
sv/sorted_set_insert_queue_top.sv
bench/tb_sorted_set_insert_queue_top.sv
